// ===== rtl/textured_quad_edge_setup_macros.svh =====
// Assertion macros for the textured quad edge setup block.
`ifndef TEXTURED_QUAD_EDGE_SETUP_MACROS_SVH
`define TEXTURED_QUAD_EDGE_SETUP_MACROS_SVH
`ifndef SYNTH
`define TQES_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TQES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TQES_ASSERT(lbl, prop, msg)
`define TQES_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/tqes_pkg.sv =====
// Shared types, constants and texture corner tables for the quad edge setup.
`default_nettype none
package tqes_pkg;
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int ROW_W      = 13;
	localparam int XS_W       = 28;
	localparam int XD_W       = 29;
	localparam int UV_W       = 24;
	localparam int TEX_W      = 2;
	localparam int PH_W       = 6;
	localparam int KIND_W     = 2;
	localparam int TEXC_W     = 8;
	localparam int IN_W       = 8 * COORD_BITS + TEX_W + PH_W;
	localparam int REC_BITS   = ROW_W + XS_W + XD_W + 4 * UV_W + TEX_W + PH_W;
	localparam int OUT_W      = ((REC_BITS + 7) / 8) * 8;
	localparam int PAD_W      = OUT_W - REC_BITS;
	localparam int NUM_W      = COORD_BITS + 1 + FRAC_BITS;
	localparam int DEN_W      = COORD_BITS + 1;
	localparam int CNT_W      = $clog2(NUM_W);
	localparam int USED_W     = 3;
	localparam logic [USED_W-1:0] EDGE_COUNT = USED_W'(4);

	typedef enum logic [KIND_W-1:0] {
		KIND_START = 2'd0,
		KIND_LEFT  = 2'd1,
		KIND_RIGHT = 2'd2,
		KIND_BLOCK = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		DIV_X = 2'd0,
		DIV_U = 2'd1,
		DIV_V = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] x;
	} vert_t;

	typedef struct packed {
		logic [PAD_W-1:0]       pad;
		logic [PH_W-1:0]        phase_out;
		logic [TEX_W-1:0]       texture_out;
		logic signed [UV_W-1:0] v_step;
		logic [UV_W-1:0]        v_start;
		logic signed [UV_W-1:0] u_step;
		logic [UV_W-1:0]        u_start;
		logic signed [XD_W-1:0] x_step;
		logic signed [XS_W-1:0] x_start;
		logic signed [ROW_W-1:0] row_value;
	} rec_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     side_left;
		logic     emit_edge;
		logic     emit_block;
	} cmd_t;

	typedef struct packed {
		logic out_taken;
		logic div_done;
		logic pend_l;
		logic pend_r;
		logic walk_done;
	} sts_t;

	function automatic logic [TEXC_W-1:0] tex_u(input logic [1:0] idx);
		logic [TEXC_W-1:0] r;
		case (idx)
			2'd0: r = TEXC_W'(64);
			2'd1: r = TEXC_W'(190);
			2'd2: r = TEXC_W'(190);
			default: r = TEXC_W'(64);
		endcase
		return r;
	endfunction

	function automatic logic [TEXC_W-1:0] tex_v(input logic [1:0] idx);
		logic [TEXC_W-1:0] r;
		case (idx)
			2'd0: r = TEXC_W'(4);
			2'd1: r = TEXC_W'(4);
			2'd2: r = TEXC_W'(60);
			default: r = TEXC_W'(60);
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/tqes_datapath.sv =====
// Datapath: vertex walkers, serial divider and output record register.
`default_nettype none
`include "textured_quad_edge_setup_macros.svh"
module tqes_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tqes_pkg::cmd_t                cmd,
	output tqes_pkg::sts_t                     sts,
	input  wire logic [tqes_pkg::IN_W-1:0]     in_data,
	output logic                               out_tvalid,
	input  wire logic                          out_tready,
	output logic [tqes_pkg::OUT_W-1:0]         out_tdata,
	output logic [tqes_pkg::KIND_W-1:0]        out_tuser,
	output logic                               out_tlast
);
	localparam int CB = tqes_pkg::COORD_BITS;
	localparam int FB = tqes_pkg::FRAC_BITS;
	localparam int NW = tqes_pkg::NUM_W;
	localparam int DW = tqes_pkg::DEN_W;

	tqes_pkg::vert_t lv_q [4];
	tqes_pkg::vert_t rv_q [4];
	logic [1:0] ls_q, rs_q;
	logic signed [CB-1:0] row_q;
	logic [tqes_pkg::USED_W-1:0] used_q;
	logic pend_l_q, pend_r_q;

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q, den_q;
	logic neg_q, busy_q;
	logic [tqes_pkg::CNT_W-1:0] cnt_q;
	tqes_pkg::div_sel_t sel_q;
	logic signed [tqes_pkg::XD_W-1:0] xstep_q;
	logic signed [tqes_pkg::UV_W-1:0] ustep_q, vstep_q;

	tqes_pkg::rec_t rec_q;
	tqes_pkg::kind_t kind_q;
	logic ovalid_q, olast_q;

	logic walk_done;
	logic emit_any;
	assign walk_done = (used_q >= tqes_pkg::EDGE_COUNT);
	assign emit_any = cmd.load || cmd.emit_edge || cmd.emit_block;

	tqes_pkg::vert_t vin [4];
	logic [1:0] top;
	logic signed [CB-1:0] miny;
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			vin[i].x = in_data[2*CB*i +: CB];
			vin[i].y = in_data[2*CB*i+CB +: CB];
		end
		top = 2'd0;
		miny = vin[0].y;
		for (int i = 1; i < 4; i++) begin
			if (vin[i].y < miny) begin
				miny = vin[i].y;
				top = 2'(i);
			end
		end
	end

	tqes_pkg::vert_t sv, dv;
	logic [1:0] si, di;
	logic signed [DW-1:0] dy, dyz;
	logic [DW-1:0] dy_mag;
	logic signed [DW-1:0] dx;
	logic signed [tqes_pkg::TEXC_W:0] dt;
	logic signed [NW:0] num;
	logic [NW-1:0] num_mag;
	always_comb begin
		sv = cmd.side_left ? lv_q[0] : rv_q[0];
		dv = cmd.side_left ? lv_q[1] : rv_q[1];
		si = cmd.side_left ? ls_q : rs_q;
		di = cmd.side_left ? ls_q + 2'd1 : rs_q - 2'd1;
		dy = DW'(dv.y) - DW'(sv.y);
		dyz = (dy == '0) ? DW'(1) : dy;
		dy_mag = dyz[DW-1] ? DW'(-dyz) : dyz;
		dx = DW'(dv.x) - DW'(sv.x);
		case (cmd.div_sel)
			tqes_pkg::DIV_X: dt = '0;
			tqes_pkg::DIV_U: dt = $signed({1'b0, tqes_pkg::tex_u(di)})
				- $signed({1'b0, tqes_pkg::tex_u(si)});
			default: dt = $signed({1'b0, tqes_pkg::tex_v(di)})
				- $signed({1'b0, tqes_pkg::tex_v(si)});
		endcase
		if (cmd.div_sel == tqes_pkg::DIV_X) begin
			num = (NW+1)'(dx) <<< FB;
		end else begin
			num = (NW+1)'(dt) <<< FB;
		end
		num_mag = num[NW] ? NW'(-num) : NW'(num);
	end

	logic [DW:0] trial;
	logic ge, done;
	logic [NW-1:0] nquo;
	logic [DW-1:0] nrem;
	logic signed [NW:0] qs;
	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		ge = trial >= {1'b0, den_q};
		nrem = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
		nquo = {quo_q[NW-2:0], ge};
		done = busy_q && (cnt_q == tqes_pkg::CNT_W'(NW - 1));
		qs = neg_q ? -$signed({1'b0, nquo}) : $signed({1'b0, nquo});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			busy_q <= !done;
			cnt_q <= cnt_q + tqes_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= num_mag;
			rem_q <= '0;
			den_q <= dy_mag;
			neg_q <= num[NW] ^ dyz[DW-1];
			sel_q <= cmd.div_sel;
		end else if (busy_q) begin
			quo_q <= nquo;
			rem_q <= nrem;
		end
		if (done) begin
			case (sel_q)
				tqes_pkg::DIV_X: xstep_q <= qs[tqes_pkg::XD_W-1:0];
				tqes_pkg::DIV_U: ustep_q <= qs[tqes_pkg::UV_W-1:0];
				default: vstep_q <= qs[tqes_pkg::UV_W-1:0];
			endcase
		end
	end

	logic signed [CB-1:0] yd1, yd2, ymin;
	logic signed [tqes_pkg::ROW_W-1:0] rows;
	always_comb begin
		yd1 = lv_q[1].y;
		yd2 = rv_q[1].y;
		ymin = (yd1 < yd2) ? yd1 : yd2;
		rows = tqes_pkg::ROW_W'(ymin) - tqes_pkg::ROW_W'(row_q);
		if (rows[tqes_pkg::ROW_W-1]) begin
			rows = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			pend_l_q <= 1'b0;
			pend_r_q <= 1'b0;
		end else if (cmd.load) begin
			used_q <= '0;
			pend_l_q <= 1'b1;
			pend_r_q <= 1'b1;
		end else if (cmd.emit_edge) begin
			if (cmd.side_left) begin
				pend_l_q <= 1'b0;
			end else begin
				pend_r_q <= 1'b0;
			end
		end else if (cmd.emit_block) begin
			if (yd1 == yd2) begin
				used_q <= used_q + tqes_pkg::USED_W'(2);
				pend_l_q <= 1'b1;
				pend_r_q <= 1'b1;
			end else if (yd1 < yd2) begin
				used_q <= used_q + tqes_pkg::USED_W'(1);
				pend_l_q <= 1'b1;
			end else begin
				used_q <= used_q + tqes_pkg::USED_W'(1);
				pend_r_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < 4; k++) begin
				lv_q[k] <= vin[top + 2'(k)];
				rv_q[k] <= vin[top - 2'(k)];
			end
			ls_q <= top;
			rs_q <= top;
			row_q <= miny;
		end else if (cmd.emit_block) begin
			row_q <= ymin;
			if (yd1 <= yd2) begin
				for (int k = 0; k < 4; k++) begin
					lv_q[k] <= lv_q[2'(k + 1)];
				end
				ls_q <= ls_q + 2'd1;
			end
			if (yd2 <= yd1) begin
				for (int k = 0; k < 4; k++) begin
					rv_q[k] <= rv_q[2'(k + 1)];
				end
				rs_q <= rs_q - 2'd1;
			end
		end
	end

	logic taken;
	assign taken = ovalid_q && out_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit_any) begin
			ovalid_q <= 1'b1;
		end else if (taken) begin
			ovalid_q <= 1'b0;
		end
	end

	localparam logic [tqes_pkg::XS_W-1:0] HALF_X = tqes_pkg::XS_W'(1) << (FB - 1);
	localparam logic [tqes_pkg::UV_W-1:0] HALF_UV = tqes_pkg::UV_W'(1) << (FB - 1);

	tqes_pkg::rec_t rec_d;
	tqes_pkg::kind_t kind_d;
	logic olast_d;
	always_comb begin
		rec_d = rec_q;
		kind_d = kind_q;
		olast_d = olast_q;
		if (cmd.load) begin
			rec_d = '0;
			rec_d.row_value = tqes_pkg::ROW_W'(miny);
			rec_d.texture_out = in_data[8*CB +: tqes_pkg::TEX_W];
			rec_d.phase_out = in_data[8*CB+tqes_pkg::TEX_W +: tqes_pkg::PH_W]
				+ tqes_pkg::PH_W'(1);
			kind_d = tqes_pkg::KIND_START;
			olast_d = 1'b0;
		end else if (cmd.emit_edge) begin
			rec_d = '0;
			rec_d.x_start = (tqes_pkg::XS_W'(sv.x) << FB) + HALF_X;
			rec_d.x_step = xstep_q;
			rec_d.u_start = (tqes_pkg::UV_W'(tqes_pkg::tex_u(si)) << FB) + HALF_UV;
			rec_d.u_step = ustep_q;
			rec_d.v_start = (tqes_pkg::UV_W'(tqes_pkg::tex_v(si)) << FB) + HALF_UV;
			rec_d.v_step = vstep_q;
			kind_d = cmd.side_left ? tqes_pkg::KIND_LEFT : tqes_pkg::KIND_RIGHT;
			olast_d = walk_done && !(cmd.side_left ? pend_r_q : pend_l_q);
		end else if (cmd.emit_block) begin
			rec_d = '0;
			rec_d.row_value = rows;
			kind_d = tqes_pkg::KIND_BLOCK;
			olast_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rec_q <= rec_d;
		kind_q <= kind_d;
		olast_q <= olast_d;
	end

	assign out_tvalid = ovalid_q;
	assign out_tdata = rec_q;
	assign out_tuser = kind_q;
	assign out_tlast = olast_q;

	assign sts.out_taken = taken;
	assign sts.div_done = done;
	assign sts.pend_l = pend_l_q;
	assign sts.pend_r = pend_r_q;
	assign sts.walk_done = walk_done;

	`TQES_ASSERT(a_div_idle, cmd.div_start |-> (!busy_q || done), "divider restarted while busy")
	`TQES_ASSERT(a_emit_free, emit_any |-> (!ovalid_q || out_tready), "record overwritten")
	`TQES_ASSERT(a_last_end, (ovalid_q && olast_q) |-> (!pend_l_q && !pend_r_q && walk_done), "early last")
	`TQES_ASSERT_NEXT(a_load_start, cmd.load, ovalid_q && kind_q == tqes_pkg::KIND_START, "no start record")
endmodule
`default_nettype wire

// ===== rtl/tqes_ctrl.sv =====
// Controller: sequences start, edge divisions and row block records.
`default_nettype none
module tqes_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_tvalid,
	output logic                in_tready,
	input  wire tqes_pkg::sts_t sts,
	output tqes_pkg::cmd_t      cmd
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_OUT   = 6'b000010,
		ST_DIV_X = 6'b000100,
		ST_DIV_U = 6'b001000,
		ST_DIV_V = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic side_q, side_d;

	always_comb begin
		state_d = state_q;
		side_d = side_q;
		cmd = '0;
		cmd.side_left = side_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_tvalid) begin
					cmd.load = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				cmd.side_left = sts.pend_l;
				if (sts.out_taken) begin
					if (sts.pend_l || sts.pend_r) begin
						cmd.div_start = 1'b1;
						cmd.div_sel = tqes_pkg::DIV_X;
						side_d = sts.pend_l;
						state_d = ST_DIV_X;
					end else if (sts.walk_done) begin
						state_d = ST_IDLE;
					end else begin
						cmd.emit_block = 1'b1;
					end
				end
			end
			ST_DIV_X: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel = tqes_pkg::DIV_U;
					state_d = ST_DIV_U;
				end
			end
			ST_DIV_U: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel = tqes_pkg::DIV_V;
					state_d = ST_DIV_V;
				end
			end
			ST_DIV_V: begin
				if (sts.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit_edge = 1'b1;
				state_d = ST_OUT;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			side_q <= 1'b0;
		end else begin
			state_q <= state_d;
			side_q <= side_d;
		end
	end

	assign in_tready = (state_q == ST_IDLE);
endmodule
`default_nettype wire

// ===== rtl/textured_quad_edge_setup.sv =====
// Top level of the textured quad edge setup block.
// The start record is registered and valid in the cycle after the input transaction;
// each edge record follows once the previous record is taken and the serial divider
// has run three divisions (x, u and v step). A new quad is accepted only in idle,
// after the last record of the previous quad is taken.
// Reset: arst_n clears the controller to idle and drops the output valid.
`default_nettype none
module textured_quad_edge_setup (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, vert3_x, vert3_y,
	// texture_sel, phase_in
	input  wire logic [tqes_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// row_value, x_start, x_step, u_start, u_step, v_start, v_step,
	// texture_out, phase_out, zero pad
	output logic [tqes_pkg::OUT_W-1:0]        m_axis_tdata,
	// kind
	output logic [tqes_pkg::KIND_W-1:0]       m_axis_tuser,
	output logic                              m_axis_tlast
);
	tqes_pkg::cmd_t cmd;
	tqes_pkg::sts_t sts;

	tqes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_axis_tvalid),
		.in_tready (s_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tqes_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_data    (s_axis_tdata),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser),
		.out_tlast  (m_axis_tlast)
	);
endmodule
`default_nettype wire

// ===== sim/tb_textured_quad_edge_setup.sv =====
// Self-checking testbench for the textured quad edge setup block: directed and random quads.
`default_nettype none
module tb_textured_quad_edge_setup;
	typedef struct {
		logic [tqes_pkg::KIND_W-1:0] kind;
		logic [tqes_pkg::OUT_W-1:0] data;
		logic last;
	} edge_rec_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [tqes_pkg::IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [tqes_pkg::OUT_W-1:0] m_axis_tdata;
	logic [tqes_pkg::KIND_W-1:0] m_axis_tuser;
	logic m_axis_tlast;

	edge_rec_t expected_recs[$];
	int errors;
	int idle_pct;
	int quiet_cycles = 0;
	bit done;

	textured_quad_edge_setup u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint corner_u(int i);
		return (i == 1 || i == 2) ? 190 : 64;
	endfunction

	function automatic longint corner_v(int i);
		return (i >= 2) ? 60 : 4;
	endfunction

	function automatic edge_rec_t edge_setup(tqes_pkg::kind_t k, longint px[4], longint py[4],
		int s, int d);
		edge_rec_t e;
		tqes_pkg::rec_t r;
		longint dy;
		dy = py[d] - py[s];
		if (dy == 0)
			dy = 1;
		r = '0;
		r.x_start = tqes_pkg::XS_W'(px[s] * 65536 + 32768);
		r.x_step = tqes_pkg::XD_W'(((px[d] - px[s]) * 65536) / dy);
		r.u_start = tqes_pkg::UV_W'(corner_u(s) * 65536 + 32768);
		r.u_step = tqes_pkg::UV_W'(((corner_u(d) - corner_u(s)) * 65536) / dy);
		r.v_start = tqes_pkg::UV_W'(corner_v(s) * 65536 + 32768);
		r.v_step = tqes_pkg::UV_W'(((corner_v(d) - corner_v(s)) * 65536) / dy);
		e.kind = k;
		e.data = r;
		e.last = 1'b0;
		return e;
	endfunction

	function automatic edge_rec_t row_rec(tqes_pkg::kind_t k, longint rows);
		edge_rec_t e;
		tqes_pkg::rec_t r;
		r = '0;
		r.row_value = tqes_pkg::ROW_W'(rows);
		e.kind = k;
		e.data = r;
		e.last = 1'b0;
		return e;
	endfunction

	task automatic predict_quad(logic [tqes_pkg::IN_W-1:0] q);
		longint px[4], py[4];
		int top, s1, s2, d1, d2, used;
		longint row, m, rows;
		edge_rec_t e;
		tqes_pkg::rec_t r;
		edge_rec_t recs[$];
		for (int i = 0; i < 4; i++) begin
			px[i] = longint'($signed(q[24*i +: 12]));
			py[i] = longint'($signed(q[24*i+12 +: 12]));
		end
		top = 0;
		for (int i = 1; i < 4; i++)
			if (py[i] < py[top])
				top = i;
		row = py[top];
		e = row_rec(tqes_pkg::KIND_START, row);
		r = e.data;
		r.texture_out = q[96 +: 2];
		r.phase_out = q[98 +: 6] + 6'd1;
		e.data = r;
		recs.push_back(e);
		s1 = top; d1 = (s1 + 1) & 3;
		s2 = top; d2 = (s2 + 3) & 3;
		recs.push_back(edge_setup(tqes_pkg::KIND_LEFT, px, py, s1, d1));
		recs.push_back(edge_setup(tqes_pkg::KIND_RIGHT, px, py, s2, d2));
		used = 0;
		while (used < 4) begin
			m = (py[d1] < py[d2]) ? py[d1] : py[d2];
			rows = m - row;
			if (rows < 0)
				rows = 0;
			recs.push_back(row_rec(tqes_pkg::KIND_BLOCK, rows));
			row = m;
			if (py[d1] == py[d2]) begin
				s1 = d1; d1 = (s1 + 1) & 3;
				s2 = d2; d2 = (s2 + 3) & 3;
				used += 2;
				recs.push_back(edge_setup(tqes_pkg::KIND_LEFT, px, py, s1, d1));
				recs.push_back(edge_setup(tqes_pkg::KIND_RIGHT, px, py, s2, d2));
			end else if (py[d1] < py[d2]) begin
				s1 = d1; d1 = (s1 + 1) & 3;
				used += 1;
				recs.push_back(edge_setup(tqes_pkg::KIND_LEFT, px, py, s1, d1));
			end else begin
				s2 = d2; d2 = (s2 + 3) & 3;
				used += 1;
				recs.push_back(edge_setup(tqes_pkg::KIND_RIGHT, px, py, s2, d2));
			end
		end
		recs[recs.size()-1].last = 1'b1;
		foreach (recs[i])
			expected_recs.push_back(recs[i]);
	endtask

	task automatic report_mismatch(string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	task automatic send_quad(logic [tqes_pkg::IN_W-1:0] q);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct)
			@(negedge clk);
		s_axis_tdata <= q;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_quad(q);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	function automatic logic [tqes_pkg::IN_W-1:0] pack_quad(int x[4], int y[4], int tex, int ph);
		logic [tqes_pkg::IN_W-1:0] q;
		for (int i = 0; i < 4; i++) begin
			q[24*i +: 12] = 12'(x[i]);
			q[24*i+12 +: 12] = 12'(y[i]);
		end
		q[96 +: 2] = 2'(tex);
		q[98 +: 6] = 6'(ph);
		return q;
	endfunction

	function automatic logic [tqes_pkg::IN_W-1:0] random_quad();
		int x[4], y[4];
		logic [tqes_pkg::IN_W-1:0] q;
		if ($urandom_range(3) == 0)
			return tqes_pkg::IN_W'({$urandom, $urandom, $urandom, $urandom});
		for (int i = 0; i < 4; i++) begin
			x[i] = $urandom_range(200) - 100;
			y[i] = $urandom_range(200) - 100;
			if ($urandom_range(5) == 0)
				y[i] = y[0];
		end
		q = pack_quad(x, y, $urandom_range(3), $urandom_range(63));
		return q;
	endfunction

	task automatic test_directed();
		int x[4], y[4];
		x = '{-2048, 2047, 2047, -2048}; y = '{-2048, -2048, 2047, 2047};
		send_quad(pack_quad(x, y, 0, 63));
		x = '{2047, -2048, -2048, 2047}; y = '{2047, 2047, -2048, -2048};
		send_quad(pack_quad(x, y, 3, 0));
		x = '{0, 10, 10, 0}; y = '{5, 5, 5, 5};
		send_quad(pack_quad(x, y, 1, 31));
		x = '{0, 50, 0, -50}; y = '{0, 20, 40, 20};
		send_quad(pack_quad(x, y, 2, 32));
		x = '{0, 30, -10, 40}; y = '{0, 40, 10, 20};
		send_quad(pack_quad(x, y, 1, 5));
		x = '{5, 6, 7, 8}; y = '{9, 3, 3, 1};
		send_quad(pack_quad(x, y, 2, 62));
		x = '{-2048, 2047, -2048, 2047}; y = '{2047, -2048, 2047, -2048};
		send_quad(pack_quad(x, y, 0, 1));
		send_quad('1);
		send_quad('0);
	endtask

	task automatic test_drain_pause();
		send_quad(random_quad());
		while (expected_recs.size() != 0)
			@(negedge clk);
		send_quad(random_quad());
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			idle_pct = (i >= n / 3 && i < n / 2) ? 0 : 18;
			send_quad(random_quad());
		end
	endtask

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= idle_pct);

	always @(posedge clk) begin
		edge_rec_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_recs.size() == 0) begin
				report_mismatch("record with none expected");
			end else begin
				e = expected_recs.pop_front();
				if (m_axis_tuser !== e.kind)
					report_mismatch($sformatf("kind %0d want %0d", m_axis_tuser, e.kind));
				if (m_axis_tdata !== e.data)
					report_mismatch($sformatf("data %h want %h", m_axis_tdata, e.data));
				if (m_axis_tlast !== e.last)
					report_mismatch($sformatf("last %0b want %0b", m_axis_tlast, e.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (!done && quiet_cycles > 20000) begin
			$display("tb_textured_quad_edge_setup: FAIL");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_pct = 18;
		done = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_drain_pause();
		test_random(260);
		idle_pct = 18;
		while (expected_recs.size() != 0)
			@(negedge clk);
		done = 1'b1;
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_recs.size() == 0)
			$display("tb_textured_quad_edge_setup: PASS");
		else
			$display("tb_textured_quad_edge_setup: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
